/* hdl/mbik_pkg.sv */
// ----------------------------------------------------------------------------
// mbik_pkg: shared constants for the mobile base inverse kinematics block
// Register map, base type codes, CORDIC tables and fixed wheel angles.
// ----------------------------------------------------------------------------
package mbik_pkg;

   // Configuration port: byte address width and register indexes
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_BASE_TYPE   = 3'd0;
   localparam logic [2:0] REG_CIRC_RECIP  = 3'd1;
   localparam logic [2:0] REG_BODY_CIRC   = 3'd2;
   localparam logic [2:0] REG_SPEED_LIMIT = 3'd3;
   localparam logic [2:0] REG_BODY_RADIUS = 3'd4;

   // Base type codes
   localparam logic [2:0] BASE_DIFF    = 3'd0;
   localparam logic [2:0] BASE_SKID    = 3'd1;
   localparam logic [2:0] BASE_MECANUM = 3'd2;
   localparam logic [2:0] BASE_OMNI4   = 3'd3;
   localparam logic [2:0] BASE_OMNI3   = 3'd4;

   // Register reset values
   localparam logic [2:0]  RST_BASE_TYPE   = BASE_MECANUM;
   localparam logic [15:0] RST_CIRC_RECIP  = 16'd3259;
   localparam logic [15:0] RST_BODY_CIRC   = 16'd3860;
   localparam logic [14:0] RST_SPEED_LIMIT = 15'd10240;
   localparam logic [15:0] RST_BODY_RADIUS = 16'd614;

   // CORDIC: iteration count, start gain (Q30), arctangents (2^32 per turn)
   localparam int CORDIC_ITERS = 16;
   localparam int CORDIC_W     = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   // Four-wheel omni wheel angles: 45, 135, 225, 315 degrees
   localparam logic [15:0] OMNI4_OFFS [4] = '{16'd8192, 16'd24576, 16'd40960, 16'd57344};

   // Three-wheel omni: sine and cosine at 30, 150, 270 degrees (Q15)
   localparam logic signed [17:0] OMNI3_SIN [4] = '{18'sd16384, 18'sd16384, -18'sd32768, 18'sd0};
   localparam logic signed [17:0] OMNI3_COS [4] = '{18'sd28378, -18'sd28378, 18'sd0, 18'sd0};

endpackage

/* hdl/mbik_if.sv */
// ----------------------------------------------------------------------------
// mbik_if: item channels of the mobile base inverse kinematics block
// Valid/ready channels for velocity commands and wheel speed results.
// ----------------------------------------------------------------------------
interface mbik_req_if #(parameter int VEL_WIDTH = 16);
   logic                        valid;
   logic                        ready;
   logic signed [VEL_WIDTH-1:0] vel_fwd;
   logic signed [VEL_WIDTH-1:0] vel_side;
   logic signed [VEL_WIDTH-1:0] turn_rate;
   logic [15:0]                 heading;

   modport source (output valid, output vel_fwd, output vel_side, output turn_rate,
                   output heading, input ready);
   modport sink   (input valid, input vel_fwd, input vel_side, input turn_rate,
                   input heading, output ready);
endinterface

interface mbik_rsp_if #(parameter int SPEED_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SPEED_WIDTH-1:0] wheel_a;
   logic signed [SPEED_WIDTH-1:0] wheel_b;
   logic signed [SPEED_WIDTH-1:0] wheel_c;
   logic signed [SPEED_WIDTH-1:0] wheel_d;

   modport source (output valid, output wheel_a, output wheel_b, output wheel_c,
                   output wheel_d, input ready);
   modport sink   (input valid, input wheel_a, input wheel_b, input wheel_c,
                   input wheel_d, output ready);
endinterface

/* hdl/mbik_cordic.sv */
// ----------------------------------------------------------------------------
// mbik_cordic: pipelined sine/cosine of a 16-bit binary angle
// Folds the angle into -90..90 degrees, runs 16 rotation stages, rounds to Q15.
// Seventeen register stages, all advanced by one enable.
// ----------------------------------------------------------------------------
module mbik_cordic (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output logic signed [17:0] sin_out,
   output logic signed [17:0] cos_out
);
   import mbik_pkg::*;

   localparam int N = CORDIC_ITERS;

   logic signed [CORDIC_W-1:0] x_ff [N];
   logic signed [CORDIC_W-1:0] y_ff [N];
   logic signed [CORDIC_W-1:0] z_ff [N];
   logic                       flip_ff [N];
   logic signed [CORDIC_W-1:0] x_src [N];
   logic signed [CORDIC_W-1:0] y_src [N];
   logic signed [CORDIC_W-1:0] z_src [N];
   logic                       flip_src [N];
   logic signed [17:0]         sin_ff, cos_ff, sin_in, cos_in;
   logic [15:0]                fold_ang;
   logic                       fold_flip;

   // Fold the second and third quadrants by half a turn
   always_comb begin
      fold_flip = (angle[15:14] == 2'd1) || (angle[15:14] == 2'd2);
      fold_ang  = fold_flip ? (angle + 16'h8000) : angle;
   end

   assign x_src[0]    = CORDIC_GAIN;
   assign y_src[0]    = '0;
   assign z_src[0]    = {{(CORDIC_W-32){fold_ang[15]}}, fold_ang, 16'h0000};
   assign flip_src[0] = fold_flip;

   genvar i;
   generate
      for (i = 1; i < N; i++) begin : g_src
         assign x_src[i]    = x_ff[i-1];
         assign y_src[i]    = y_ff[i-1];
         assign z_src[i]    = z_ff[i-1];
         assign flip_src[i] = flip_ff[i-1];
      end

      // One rotation per stage
      for (i = 0; i < N; i++) begin : g_rot
         always_ff @(posedge clock) begin
            if (en) begin
               if (!z_src[i][CORDIC_W-1]) begin
                  x_ff[i] <= x_src[i] - (y_src[i] >>> i);
                  y_ff[i] <= y_src[i] + (x_src[i] >>> i);
                  z_ff[i] <= z_src[i] - CORDIC_W'(ATAN_TAB[i]);
               end else begin
                  x_ff[i] <= x_src[i] + (y_src[i] >>> i);
                  y_ff[i] <= y_src[i] - (x_src[i] >>> i);
                  z_ff[i] <= z_src[i] + CORDIC_W'(ATAN_TAB[i]);
               end
               flip_ff[i] <= flip_src[i];
            end
         end
      end
   endgenerate

   // Round to Q15 and undo the fold
   always_comb begin
      cos_in = 18'((x_ff[N-1] + CORDIC_W'(16384)) >>> 15);
      sin_in = 18'((y_ff[N-1] + CORDIC_W'(16384)) >>> 15);
      if (flip_ff[N-1]) begin
         cos_in = -cos_in;
         sin_in = -sin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

/* hdl/mobile_base_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// mobile_base_inverse_kinematics: wheel speeds from a base velocity command
// Converts forward, sideways and turn velocity plus heading into four clamped
// wheel speeds for differential, skid, mecanum, four- and three-wheel omni.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command item (vel_fwd, vel_side, turn_rate, heading);
//   rsp_chan returns one item of four wheel speeds for each command, in order.
//   Both are valid/ready channels; an item moves when valid and ready are high.
//   The csr_ APB port holds base type, wheel circumference reciprocal, body
//   circumference, speed limit and body radius; write it only while idle.
// Depth: 25 register stages.
// Throughput: one item per cycle unless stalled. The 17-stage pair-scaling
//   divider and the 17-stage CORDIC running beside it set the depth, not
//   the rate.
// Reset: synchronous; clears all valid bits and loads register defaults.
// Stall: when a result waits unaccepted, every stage holds and req_chan.ready
//   drops; bubbles ahead of the waiting result are not squeezed out.
// ----------------------------------------------------------------------------
module mobile_base_inverse_kinematics #(
   parameter int VEL_WIDTH   = 16,
   parameter int SPEED_WIDTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   mbik_req_if.sink                    req_chan,
   mbik_rsp_if.source                  rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mbik_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import mbik_pkg::*;

   localparam int V    = VEL_WIDTH;
   localparam int PW   = V + 17;   // command times reciprocal
   localparam int W    = V + 15;   // inner speed, 16 fraction bits
   localparam int T1W  = V + 5;    // turn rate times circumference
   localparam int PTW  = V + 22;
   localparam int SUW  = W + 1;    // magnitude sums
   localparam int DVW  = W + 18;   // divider remainder
   localparam int MW   = W + 19;   // products on inner speeds
   localparam int WW   = W + 5;    // mixed wheel value
   localparam int LIMW = 21;
   localparam int NST  = 25;
   localparam int QB   = 17;       // quotient bits
   localparam logic signed [33:0] SHI = (34'sd1 <<< (SPEED_WIDTH - 1)) - 34'sd1;
   localparam logic signed [33:0] SLO = -SHI - 34'sd1;

   typedef struct packed {
      logic signed [W-1:0] x;
      logic signed [W-1:0] y;
      logic signed [W-1:0] t;
      logic                scl;
      logic [SUW-1:0]      dsr;
      logic [DVW-1:0]      rem;
      logic [QB-1:0]       quo;
      logic [15:0]         hd;
   } dv_pl_type;

   // ---------------------------------------------------------------- config
   logic [2:0]  base_type_ff;
   logic [15:0] circ_recip_ff, body_circ_ff, body_radius_ff;
   logic [14:0] speed_limit_ff;
   logic        csr_wr;
   logic [2:0]  csr_idx;
   logic [LIMW-1:0]    lim;
   logic signed [16:0] rc_s, bc_s, br_s;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Write registers; ignore addresses beyond the map
   always_ff @(posedge clock) begin
      if (reset) begin
         base_type_ff   <= RST_BASE_TYPE;
         circ_recip_ff  <= RST_CIRC_RECIP;
         body_circ_ff   <= RST_BODY_CIRC;
         speed_limit_ff <= RST_SPEED_LIMIT;
         body_radius_ff <= RST_BODY_RADIUS;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_BASE_TYPE:   base_type_ff   <= csr_pwdata[2:0];
            REG_CIRC_RECIP:  circ_recip_ff  <= csr_pwdata[15:0];
            REG_BODY_CIRC:   body_circ_ff   <= csr_pwdata[15:0];
            REG_SPEED_LIMIT: speed_limit_ff <= csr_pwdata[14:0];
            REG_BODY_RADIUS: body_radius_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (csr_idx)
         REG_BASE_TYPE:   csr_prdata = {29'd0, base_type_ff};
         REG_CIRC_RECIP:  csr_prdata = {16'd0, circ_recip_ff};
         REG_BODY_CIRC:   csr_prdata = {16'd0, body_circ_ff};
         REG_SPEED_LIMIT: csr_prdata = {17'd0, speed_limit_ff};
         REG_BODY_RADIUS: csr_prdata = {16'd0, body_radius_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign lim  = {speed_limit_ff, 6'd0};
   assign rc_s = signed'({1'b0, circ_recip_ff});
   assign bc_s = signed'({1'b0, body_circ_ff});
   assign br_s = signed'({1'b0, body_radius_ff});

   // ---------------------------------------------------------------- flow
   logic [NST:1] vld_ff;
   logic         stage_en;

   assign stage_en       = !vld_ff[NST] || rsp_chan.ready;
   assign req_chan.ready = stage_en;

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (stage_en) begin
         vld_ff <= {vld_ff[NST-1:1], req_chan.valid};
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Scale commands to wheel revolutions
   logic signed [PW-1:0] s1_px_ff, s1_py_ff, s1_pt_ff;
   logic                 s1_vsz_ff, s1_wzz_ff;
   logic [15:0]          s1_hd_ff;

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s1_px_ff  <= PW'(req_chan.vel_fwd) * PW'(rc_s);
         s1_py_ff  <= PW'(req_chan.vel_side) * PW'(rc_s);
         s1_pt_ff  <= PW'(req_chan.turn_rate) * PW'(bc_s);
         s1_vsz_ff <= (req_chan.vel_side == '0);
         s1_wzz_ff <= (req_chan.turn_rate == '0);
         s1_hd_ff  <= req_chan.heading;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [W-1:0]   s2_x_ff, s2_y_ff;
   logic signed [PTW-1:0] s2_pt_ff;
   logic                  s2_vsz_ff, s2_wzz_ff;
   logic [15:0]           s2_hd_ff;
   logic signed [T1W-1:0] s2_t1;

   assign s2_t1 = T1W'(s1_pt_ff >>> 12);

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s2_x_ff   <= W'(s1_px_ff >>> 6);
         s2_y_ff   <= W'(s1_py_ff >>> 6);
         s2_pt_ff  <= PTW'(s2_t1) * PTW'(rc_s);
         s2_vsz_ff <= s1_vsz_ff;
         s2_wzz_ff <= s1_wzz_ff;
         s2_hd_ff  <= s1_hd_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Pick the active pair and decide on scaling
   dv_pl_type           s3_ff, s3_in;
   logic signed [W-1:0] s3_t;
   logic [W-1:0]        ax, ay, at;
   logic [SUW-1:0]      sxy, sxt;
   logic                mode_xy, mode_xt;

   always_comb begin
      s3_t    = W'(s2_pt_ff >>> 6);
      ax      = s2_x_ff[W-1] ? W'(-s2_x_ff) : W'(s2_x_ff);
      ay      = s2_y_ff[W-1] ? W'(-s2_y_ff) : W'(s2_y_ff);
      at      = s3_t[W-1] ? W'(-s3_t) : W'(s3_t);
      sxy     = SUW'(ax) + SUW'(ay);
      sxt     = SUW'(ax) + SUW'(at);
      mode_xy = s2_wzz_ff && (sxy >= SUW'(lim));
      mode_xt = !mode_xy && s2_vsz_ff && (sxt >= SUW'(lim));
      s3_in.x   = s2_x_ff;
      s3_in.y   = s2_y_ff;
      s3_in.t   = s3_t;
      s3_in.dsr = mode_xy ? sxy : sxt;
      s3_in.scl = (mode_xy || mode_xt) && (s3_in.dsr != '0);
      s3_in.rem = DVW'(lim) << 16;
      s3_in.quo = '0;
      s3_in.hd  = s2_hd_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------------- divider
   // One quotient bit per stage, most significant first
   dv_pl_type dv_src [QB];
   dv_pl_type dv_in  [QB];
   dv_pl_type dv_ff  [QB];

   assign dv_src[0] = s3_ff;

   genvar j;
   generate
      for (j = 1; j < QB; j++) begin : g_dsrc
         assign dv_src[j] = dv_ff[j-1];
      end
      for (j = 0; j < QB; j++) begin : g_div
         logic [DVW-1:0] shd;
         always_comb begin
            shd = DVW'(dv_src[j].dsr) << (QB - 1 - j);
            dv_in[j] = dv_src[j];
            if (dv_src[j].rem >= shd) begin
               dv_in[j].rem = dv_src[j].rem - shd;
               dv_in[j].quo[QB-1-j] = 1'b1;
            end
         end
         always_ff @(posedge clock) begin
            if (stage_en) begin
               dv_ff[j] <= dv_in[j];
            end
         end
      end
   endgenerate

   // ---------------------------------------------------------------- CORDIC
   // Starts two stages into the divider so its output lands beside stage 22
   logic signed [17:0] cd_sin [4];
   logic signed [17:0] cd_cos [4];

   genvar k;
   generate
      for (k = 0; k < 4; k++) begin : g_cordic
         mbik_cordic u_cordic (
            .clock   (clock),
            .en      (stage_en),
            .angle   (dv_ff[1].hd + OMNI4_OFFS[k]),
            .sin_out (cd_sin[k]),
            .cos_out (cd_cos[k])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- stage 21
   // Multiply by the scale factor (one when not scaling)
   logic signed [MW-1:0] s21_x_ff, s21_y_ff, s21_t_ff;
   logic signed [18:0]   sc;

   assign sc = dv_ff[QB-1].scl ? signed'({2'b00, dv_ff[QB-1].quo}) : 19'sh10000;

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s21_x_ff <= MW'(dv_ff[QB-1].x) * MW'(sc);
         s21_y_ff <= MW'(dv_ff[QB-1].y) * MW'(sc);
         s21_t_ff <= MW'(dv_ff[QB-1].t) * MW'(sc);
      end
   end

   // ---------------------------------------------------------------- stage 22
   logic signed [W-1:0] s22_x_ff, s22_y_ff, s22_t_ff;

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s22_x_ff <= W'(s21_x_ff >>> 16);
         s22_y_ff <= W'(s21_y_ff >>> 16);
         s22_t_ff <= W'(s21_t_ff >>> 16);
      end
   end

   // ---------------------------------------------------------------- stage 23
   // Wheel direction products and turn term
   logic signed [MW-1:0] s23_pc_ff [4];
   logic signed [MW-1:0] s23_ps_ff [4];
   logic signed [MW-1:0] s23_rt_ff;
   logic signed [W-1:0]  s23_x_ff, s23_y_ff, s23_t_ff;
   logic signed [17:0]   ws [4];
   logic signed [17:0]   wc [4];

   generate
      for (k = 0; k < 4; k++) begin : g_prod
         assign ws[k] = (base_type_ff == BASE_OMNI4) ? cd_sin[k] : OMNI3_SIN[k];
         assign wc[k] = (base_type_ff == BASE_OMNI4) ? cd_cos[k] : OMNI3_COS[k];
         always_ff @(posedge clock) begin
            if (stage_en) begin
               s23_pc_ff[k] <= MW'(wc[k]) * MW'(s22_y_ff);
               s23_ps_ff[k] <= MW'(ws[k]) * MW'(s22_x_ff);
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s23_rt_ff <= MW'(br_s) * MW'(s22_t_ff);
         s23_x_ff  <= s22_x_ff;
         s23_y_ff  <= s22_y_ff;
         s23_t_ff  <= s22_t_ff;
      end
   end

   // ---------------------------------------------------------------- stage 24
   // Mix per base type
   logic signed [WW-1:0] s24_w_ff [4];
   logic signed [WW-1:0] s24_w_in [4];
   logic signed [WW-1:0] omni [4];
   logic signed [WW-1:0] mx, my, mt;

   always_comb begin
      mx = WW'(s23_x_ff);
      my = WW'(s23_y_ff);
      mt = WW'(s23_t_ff);
      for (int n = 0; n < 4; n++) begin
         omni[n] = WW'((s23_pc_ff[n] - s23_ps_ff[n]) >>> 15) + WW'(s23_rt_ff >>> 12);
      end
      unique case (base_type_ff)
         BASE_OMNI4: begin
            s24_w_in = omni;
         end
         BASE_OMNI3: begin
            s24_w_in[0] = omni[0];
            s24_w_in[1] = omni[1];
            s24_w_in[2] = omni[2];
            s24_w_in[3] = '0;
         end
         default: begin
            s24_w_in[0] = mx - my - mt;
            s24_w_in[1] = mx + my + mt;
            s24_w_in[2] = mx + my - mt;
            s24_w_in[3] = mx - my + mt;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         s24_w_ff <= s24_w_in;
      end
   end

   // ---------------------------------------------------------------- stage 25
   // Clamp to the limit, drop to 10 fraction bits, saturate
   function automatic logic [SPEED_WIDTH-1:0] finish_wheel(
      input logic signed [WW-1:0] v,
      input logic [LIMW-1:0]      lv
   );
      logic signed [WW-1:0]   ls;
      logic signed [WW-1:0]   cl;
      logic signed [LIMW:0]   cn;
      logic signed [33:0]     f;
      logic signed [33:0]     sat;
      ls = WW'(signed'({1'b0, lv}));
      cl = v;
      if (v > ls) cl = ls;
      else if (v < -ls) cl = -ls;
      cn = (LIMW + 1)'(cl >>> 6);
      f  = 34'(cn);
      sat = f;
      if (f > SHI) sat = SHI;
      else if (f < SLO) sat = SLO;
      return SPEED_WIDTH'(sat);
   endfunction

   logic [SPEED_WIDTH-1:0] out_ff [4];

   always_ff @(posedge clock) begin
      if (stage_en) begin
         for (int n = 0; n < 4; n++) begin
            out_ff[n] <= finish_wheel(s24_w_ff[n], lim);
         end
      end
   end

   assign rsp_chan.valid   = vld_ff[NST];
   assign rsp_chan.wheel_a = signed'(out_ff[0]);
   assign rsp_chan.wheel_b = signed'(out_ff[1]);
   assign rsp_chan.wheel_c = signed'(out_ff[2]);
   assign rsp_chan.wheel_d = signed'(out_ff[3]);

   // ---------------------------------------------------------------- checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> vld_ff[1])
      else $error("accepted item did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !stage_en |=> $stable(vld_ff))
      else $error("valid bits moved during a stall");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      vld_ff[20] && dv_ff[QB-1].scl |-> dv_ff[QB-1].rem < DVW'(dv_ff[QB-1].dsr))
      else $error("divider remainder not below divisor");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule

/* bench/mbik_wheel_checker.sv */
// ----------------------------------------------------------------------------
// mbik_wheel_checker: wheel speed predictor and scoreboard
// Watches the command, result and register ports of the inverse kinematics
// block. It predicts four wheel speeds for each accepted command and compares
// them, in order, with each accepted result.
// ----------------------------------------------------------------------------
module mbik_wheel_checker
   import mbik_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   mbik_req_if                  req,
   mbik_rsp_if                  rsp,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic                 csr_pready,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output int                   fail_count,
   output int                   wheels_pending,
   output int                   results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] d;
   } wheel_set_type;

   // Register shadow
   logic [2:0]  base_kind;
   logic [15:0] circ_recip;
   logic [15:0] body_circ;
   logic [14:0] speed_max;
   logic [15:0] body_rad;

   wheel_set_type wheel_expect_q[$];

   // Q15 sine and cosine by a 16-step CORDIC, folded into -90..90 degrees
   function automatic void cordic_sincos(input logic [15:0] ang,
                                         output longint sn, output longint cs);
      logic [15:0] u;
      logic        flip;
      longint      x, y, z, dx, dy;
      u    = ang;
      flip = (u[15:14] == 2'd1) || (u[15:14] == 2'd2);
      if (flip) u = u + 16'd32768;
      z = longint'($signed(u)) * 65536;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(ATAN_TAB[i]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(ATAN_TAB[i]);
         end
      end
      x = (x + 16384) >>> 15;
      y = (y + 16384) >>> 15;
      if (flip) begin
         x = -x; y = -y;
      end
      sn = y;
      cs = x;
   endfunction

   // Clamp to the limit, drop to 10 fraction bits, saturate to 16 bits
   function automatic logic [15:0] wheel_out(input longint v, input longint lim);
      longint r;
      r = v;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      r = r >>> 6;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic wheel_set_type predict_wheels(input logic signed [15:0] vf,
         input logic signed [15:0] vs, input logic signed [15:0] wz,
         input logic [15:0] hd);
      longint        rc, lim, x, y, t, ax, ay, at, sc, rt, sn, cs;
      longint        w[4];
      wheel_set_type ws;
      rc  = longint'(circ_recip);
      lim = longint'(speed_max) * 64;
      x   = (longint'(vf) * rc) >>> 6;
      y   = (longint'(vs) * rc) >>> 6;
      t   = (((longint'(wz) * longint'(body_circ)) >>> 12) * rc) >>> 6;
      ax  = x < 0 ? -x : x;
      ay  = y < 0 ? -y : y;
      at  = t < 0 ? -t : t;
      // Scale the active pair back under the limit
      if (ax + ay >= lim && wz == 0) begin
         if (ax + ay != 0) begin
            sc = (lim << 16) / (ax + ay);
            x  = (x * sc) >>> 16;
            y  = (y * sc) >>> 16;
         end
      end else if (ax + at >= lim && vs == 0) begin
         if (ax + at != 0) begin
            sc = (lim << 16) / (ax + at);
            x  = (x * sc) >>> 16;
            t  = (t * sc) >>> 16;
         end
      end
      rt = (longint'(body_rad) * t) >>> 12;
      if (base_kind == BASE_OMNI4) begin
         for (int k = 0; k < 4; k++) begin
            cordic_sincos(OMNI4_OFFS[k] + hd, sn, cs);
            w[k] = ((cs * y - sn * x) >>> 15) + rt;
         end
      end else if (base_kind == BASE_OMNI3) begin
         for (int k = 0; k < 3; k++)
            w[k] = ((longint'(OMNI3_COS[k]) * y - longint'(OMNI3_SIN[k]) * x) >>> 15) + rt;
         w[3] = 0;
      end else begin
         w[0] = x - y - t;
         w[1] = x + y + t;
         w[2] = x + y - t;
         w[3] = x - y + t;
      end
      ws.a = wheel_out(w[0], lim);
      ws.b = wheel_out(w[1], lim);
      ws.c = wheel_out(w[2], lim);
      ws.d = wheel_out(w[3], lim);
      return ws;
   endfunction

   // Track register writes, predict on command accept, compare on result accept
   always @(posedge clock) begin
      wheel_set_type want;
      if (reset) begin
         base_kind  <= RST_BASE_TYPE;
         circ_recip <= RST_CIRC_RECIP;
         body_circ  <= RST_BODY_CIRC;
         speed_max  <= RST_SPEED_LIMIT;
         body_rad   <= RST_BODY_RADIUS;
         wheel_expect_q.delete();
         wheels_pending <= 0;
         fail_count     <= 0;
         results_seen   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_AW-1:2])
               REG_BASE_TYPE:   base_kind  <= csr_pwdata[2:0];
               REG_CIRC_RECIP:  circ_recip <= csr_pwdata[15:0];
               REG_BODY_CIRC:   body_circ  <= csr_pwdata[15:0];
               REG_SPEED_LIMIT: speed_max  <= csr_pwdata[14:0];
               REG_BODY_RADIUS: body_rad   <= csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            wheel_expect_q.push_back(predict_wheels(req.vel_fwd, req.vel_side,
                                                    req.turn_rate, req.heading));
         if (rsp.valid && rsp.ready) begin
            results_seen <= results_seen + 1;
            if (wheel_expect_q.size() == 0) begin
               $display("%0t: unexpected result a=%0d b=%0d c=%0d d=%0d", $realtime,
                        rsp.wheel_a, rsp.wheel_b, rsp.wheel_c, rsp.wheel_d);
               fail_count <= fail_count + 1;
            end else begin
               want = wheel_expect_q.pop_front();
               if (want.a !== rsp.wheel_a || want.b !== rsp.wheel_b ||
                   want.c !== rsp.wheel_c || want.d !== rsp.wheel_d) begin
                  $display("%0t: wheel mismatch expected a=%0d b=%0d c=%0d d=%0d",
                           $realtime, want.a, want.b, want.c, want.d);
                  $display("%0t:                  actual a=%0d b=%0d c=%0d d=%0d",
                           $realtime, rsp.wheel_a, rsp.wheel_b, rsp.wheel_c, rsp.wheel_d);
                  fail_count <= fail_count + 1;
               end
            end
         end
         wheels_pending <= wheel_expect_q.size();
      end
   end
endmodule

/* bench/tb_mobile_base_inverse_kinematics.sv */
// ----------------------------------------------------------------------------
// tb_mobile_base_inverse_kinematics: regression for the wheel speed block
// Drives directed and random velocity commands over several register
// settings, with random gaps and result stalls; a checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_mobile_base_inverse_kinematics;
   import mbik_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock;
   logic              reset;
   logic              csr_psel, csr_penable, csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [31:0]       csr_pwdata, csr_prdata;
   logic              csr_pready;
   int                fail_count, wheels_pending, results_seen;
   int                cmds_sent;
   int                stall_left;
   bit                calm;

   mbik_req_if #(.VEL_WIDTH(16))   req_chan ();
   mbik_rsp_if #(.SPEED_WIDTH(16)) rsp_chan ();

   mobile_base_inverse_kinematics dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   mbik_wheel_checker chk (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .fail_count(fail_count), .wheels_pending(wheels_pending),
      .results_seen(results_seen)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly short gaps, a few long ones, none in calm stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Stall the result side at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Hold valid until the item is taken; drop it only for a gap
   task automatic send_cmd(input logic signed [15:0] vf, input logic signed [15:0] vs,
                           input logic signed [15:0] wz, input logic [15:0] hd);
      int g;
      g = pick_gap();
      if (g > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (g - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid     <= 1'b1;
      req_chan.vel_fwd   <= vf;
      req_chan.vel_side  <= vs;
      req_chan.turn_rate <= wz;
      req_chan.heading   <= hd;
      do @(posedge clock); while (!req_chan.ready);
      cmds_sent++;
   endtask

   // Stop sending and wait until every result is back
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (wheels_pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_vel();
      case ($urandom_range(0, 4))
         0, 1: return 16'($urandom());
         2:    return 16'($signed($urandom_range(0, 4095)) - 2048);
         3:    return 16'd0;
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0001;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   initial begin
      logic signed [15:0] vf, vs, wz;
      logic [15:0] extremes [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};
      logic [15:0] headings [6] = '{16'd0, 16'd16384, 16'd32768, 16'd49152,
                                    16'd65535, 16'd8191};
      reset = 1'b1;
      calm  = 1'b0;
      cmds_sent = 0;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req_chan.valid = 1'b0;
      req_chan.vel_fwd = '0; req_chan.vel_side = '0;
      req_chan.turn_rate = '0; req_chan.heading = '0;
      rsp_chan.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: zero command, field extremes, each pairing path, headings
      send_cmd(16'sd0, 16'sd0, 16'sd0, 16'd0);
      foreach (extremes[i]) send_cmd(extremes[i], 16'sd0, 16'sd0, 16'd0);
      foreach (extremes[i]) send_cmd(extremes[i], extremes[4 - i], 16'sd0, 16'd0);
      foreach (extremes[i]) send_cmd(extremes[i], 16'sd0, extremes[(i + 1) % 5], 16'd0);
      send_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0);
      send_cmd(16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF);
      drain();

      // Phases over register settings, extremes included
      for (int p = 0; p < 11; p++) begin
         csr_write(REG_BASE_TYPE, (p < 8) ? p : $urandom_range(BASE_OMNI4, BASE_OMNI3));
         csr_write(REG_CIRC_RECIP, (p == 1) ? 1 : (p == 2) ? 65535 : $urandom_range(500, 8000));
         csr_write(REG_BODY_CIRC, (p == 3) ? 0 : (p == 4) ? 65535 : $urandom_range(0, 65535));
         csr_write(REG_SPEED_LIMIT, (p == 5) ? 0 : (p == 6) ? 32767 : $urandom_range(0, 32767));
         csr_write(REG_BODY_RADIUS, (p == 7) ? 0 : (p == 8) ? 65535 : $urandom_range(0, 65535));
         // Every special heading on the omni bases
         if (p == 3 || p == 9)
            foreach (headings[h]) send_cmd(16'sd2000, -16'sd1500, 16'sd800, headings[h]);
         for (int n = 0; n < 140; n++) begin
            if (n % 50 == 0) calm = $urandom_range(0, 2) == 0;
            vf = rand_vel();
            vs = rand_vel();
            wz = rand_vel();
            // Lean on the single-pair scaling paths
            case ($urandom_range(0, 3))
               0: wz = 16'sd0;
               1: vs = 16'sd0;
               default: ;
            endcase
            send_cmd(vf, vs, wz, 16'($urandom()));
         end
         calm = 1'b0;
         drain();
      end

      $display("Covered %0d commands, %0d results, over 11 register settings and all",
               cmds_sent, results_seen);
      $display("base types, including zero and full speed limit and gain extremes.");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Hard stop
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule

/* sim.f */
hdl/mbik_pkg.sv
hdl/mbik_if.sv
hdl/mbik_cordic.sv
hdl/mobile_base_inverse_kinematics.sv
bench/mbik_wheel_checker.sv
bench/tb_mobile_base_inverse_kinematics.sv
